[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that is switched off while reset is high
`define CHK_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also holds across reset
`define CHK_ALL(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/thn_pkg.sv]
`default_nettype none

package thn_pkg;

  localparam int VertexCountDef = 1024;

  // field widths
  localparam int IdxW = 10;
  localparam int ValW = 32;
  localparam int WgtW = 17;
  localparam int NrmW = 18;
  localparam int EdgeW = ValW + 1;
  localparam int ProdW = 2 * ValW;
  localparam int AccW = ProdW + 2;
  localparam int QuoW = 19;
  localparam int NumW = 48;

  localparam logic signed [NrmW-1:0] NrmOne = 18'sd65536;

  typedef enum logic [1:0] {
    ACT_POS   = 2'd0,
    ACT_NRM   = 2'd1,
    ACT_QUERY = 2'd2
  } action_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOAD,
    S_FIT,
    S_MUL,
    S_CHK,
    S_SCALE,
    S_SQR,
    S_SQRT,
    S_DIVINIT,
    S_DIV,
    S_FIN
  } state_t;

  typedef struct packed {
    logic signed [ValW-1:0] x;
    logic signed [ValW-1:0] y;
    logic signed [ValW-1:0] z;
  } vec_t;

endpackage

`default_nettype wire

[design/triangle_hit_normal.sv]
`default_nettype none
`include "assert_macros.svh"

// Shading normal for a triangle hit. A vertex table holds positions and normals;
// action 0 writes a position, action 1 a normal, action 2 queries three vertices
// with barycentric weights. If any of the three normals is nonzero the weighted
// normal sum is used, otherwise the face normal (edge b-a cross edge c-a). The
// vector is normalized to Q1.16; a zero vector gives a zero normal and the
// degenerate flag. Every request gives one response, and no request is taken
// while one is being worked on. A write or an unused action goes straight to the
// response. A query goes through the table reads, edge halving, the one shared
// 32x32 multiplier, a zero check, magnitude scaling, the sum of squares, the
// bit-serial square root, the restoring divider that forms the three components
// and the loading of the response. A zero vector skips the normalizing. A
// response that is not taken holds the block in its last cycle; the next request
// can be taken in the same cycle that the response appears. After reset the
// normal table is cleared one entry a cycle, while no request is taken.
module triangle_hit_normal #(
  parameter int VERTEX_COUNT = thn_pkg::VertexCountDef
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 req_valid,
  output logic                                 req_ready,
  input  logic [1:0]                           action,
  input  logic [thn_pkg::IdxW-1:0]             index_a,
  input  logic [thn_pkg::IdxW-1:0]             index_b,
  input  logic [thn_pkg::IdxW-1:0]             index_c,
  input  logic signed [thn_pkg::ValW-1:0]      val_x,
  input  logic signed [thn_pkg::ValW-1:0]      val_y,
  input  logic signed [thn_pkg::ValW-1:0]      val_z,
  input  logic [thn_pkg::WgtW-1:0]             weight_a,
  input  logic [thn_pkg::WgtW-1:0]             weight_b,
  input  logic [thn_pkg::WgtW-1:0]             weight_c,
  output logic                                 rsp_valid,
  input  logic                                 rsp_ready,
  output logic signed [thn_pkg::NrmW-1:0]      normal_x,
  output logic signed [thn_pkg::NrmW-1:0]      normal_y,
  output logic signed [thn_pkg::NrmW-1:0]      normal_z,
  output logic                                 smooth_used,
  output logic                                 degenerate
);
  import thn_pkg::*;

  localparam int AW = $clog2(VERTEX_COUNT);
  localparam int XW = 17;
  localparam logic [XW-1:0] VcLim = XW'(VERTEX_COUNT);
  localparam logic [AW-1:0] ClrLast = AW'(VERTEX_COUNT - 1);

  state_t state, state_next;

  // vertex tables
  vec_t pos_mem [VERTEX_COUNT];
  vec_t nrm_mem [VERTEX_COUNT];
  vec_t pos_rd, nrm_rd;
  logic rd_ok_q;

  // request registers
  logic [IdxW-1:0] ia, ib, ic;
  logic [WgtW-1:0] wa, wb, wc;

  // control counters
  logic [AW-1:0] clr_cnt;
  logic [1:0]    ld;
  logic [3:0]    st;
  logic [4:0]    it;
  logic [1:0]    dc;

  // vertex data and vectors
  vec_t p0, n0, n1, n2;
  logic signed [EdgeW-1:0] e1x, e1y, e1z, e2x, e2y, e2z;
  logic signed [ProdW-1:0] v0, v1, v2;
  logic [ProdW-1:0] m0, m1, m2;

  // multiplier pipe
  logic signed [ValW-1:0] op_a, op_b;
  logic op_sub, op_first, op_last;
  logic [1:0] op_comp;
  logic [3:0] nsteps;
  logic issue;
  logic signed [ProdW-1:0] prod;
  logic p_valid, p_sub, p_first, p_last;
  logic [1:0] p_comp;
  logic signed [AccW-1:0] acc, acc_base, acc_next;
  logic mul_done;

  // root and divide
  logic [ProdW-1:0] sq_rem, sq_res, sq_bit, sq_trial;
  logic [ValW-1:0]  len;
  logic [ValW-1:0]  div_rem;
  logic [QuoW-1:0]  div_lo;
  logic [QuoW-1:0]  quo, quo_fin, quo_cap;
  logic [ValW:0]    div_shift;
  logic             div_ge;
  logic [ProdW-1:0] m_cur;
  logic             v_neg;
  logic [NumW-1:0]  num;
  logic signed [NrmW-1:0] q_signed;

  // result staging
  logic signed [NrmW-1:0] nx, ny, nz;
  logic smooth_r, degen_r;

  // misc control
  logic req_acc;
  logic ok_a;
  logic [XW-1:0] rd_ext;
  logic [IdxW-1:0] rd_idx;
  logic [AW-1:0] rd_addr, wr_addr, nrm_waddr;
  logic rd_ok;
  logic pos_we, nrm_we;
  vec_t wr_vec, nrm_wdata, vd, nd;
  logic any_nrm, e1_big, e2_big;
  logic [ProdW-1:0] mx;
  logic out_free;
  logic nrm_in_range, nrm_is_zero;

  function automatic logic edge_big(input logic signed [EdgeW-1:0] e);
    logic [EdgeW-1:0] m;
    m = e[EdgeW-1] ? EdgeW'(-e) : EdgeW'(e);
    return m > (EdgeW'(1) << 30);
  endfunction

  function automatic logic [ProdW-1:0] mag64(input logic signed [ProdW-1:0] v);
    return v[ProdW-1] ? ProdW'(-v) : ProdW'(v);
  endfunction

  // handshake and table addressing
  assign req_ready = (state == S_IDLE);
  assign req_acc   = req_valid && req_ready;
  assign ok_a      = XW'(index_a) < VcLim;
  assign wr_addr   = XW'(index_a) < VcLim ? AW'(XW'(index_a)) : '0;
  assign wr_vec    = '{x: val_x, y: val_y, z: val_z};
  assign pos_we    = req_acc && (action == ACT_POS) && ok_a;
  assign nrm_we    = (state == S_CLEAR) || (req_acc && (action == ACT_NRM) && ok_a);
  assign nrm_waddr = (state == S_CLEAR) ? clr_cnt : wr_addr;
  assign nrm_wdata = (state == S_CLEAR) ? vec_t'('0) : wr_vec;

  always_comb begin
    case (ld)
      2'd0:    rd_idx = ia;
      2'd1:    rd_idx = ib;
      default: rd_idx = ic;
    endcase
  end
  assign rd_ext  = XW'(rd_idx);
  assign rd_addr = rd_ext[AW-1:0];
  assign rd_ok   = rd_ext < VcLim;

  // position table
  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[wr_addr] <= wr_vec;
    end
    pos_rd <= pos_mem[rd_addr];
  end

  // normal table
  always_ff @(posedge clk) begin
    if (nrm_we) begin
      nrm_mem[nrm_waddr] <= nrm_wdata;
    end
    nrm_rd  <= nrm_mem[rd_addr];
    rd_ok_q <= rd_ok;
  end

  assign vd = rd_ok_q ? pos_rd : vec_t'('0);
  assign nd = rd_ok_q ? nrm_rd : vec_t'('0);

  assign any_nrm = (|n0) || (|n1) || (|n2);
  assign e1_big  = edge_big(e1x) || edge_big(e1y) || edge_big(e1z);
  assign e2_big  = edge_big(e2x) || edge_big(e2y) || edge_big(e2z);

  // largest magnitude for scaling
  always_comb begin
    mx = m0;
    if (m1 > mx) mx = m1;
    if (m2 > mx) mx = m2;
  end

  // multiplier operand schedule
  always_comb begin
    op_a = '0;
    op_b = '0;
    op_sub = 1'b0;
    op_first = 1'b0;
    op_last = 1'b0;
    op_comp = 2'd0;
    if (state == S_SQR) begin
      nsteps = 4'd3;
      op_first = (st == 4'd0);
      op_last  = (st == 4'd2);
      case (st)
        4'd0:    begin op_a = $signed(m0[ValW-1:0]); op_b = $signed(m0[ValW-1:0]); end
        4'd1:    begin op_a = $signed(m1[ValW-1:0]); op_b = $signed(m1[ValW-1:0]); end
        default: begin op_a = $signed(m2[ValW-1:0]); op_b = $signed(m2[ValW-1:0]); end
      endcase
    end else if (any_nrm) begin
      nsteps = 4'd9;
      case (st)
        4'd0:    begin op_a = $signed(ValW'(wa)); op_b = n0.x; op_first = 1'b1; end
        4'd1:    begin op_a = $signed(ValW'(wb)); op_b = n1.x; end
        4'd2:    begin op_a = $signed(ValW'(wc)); op_b = n2.x; op_last = 1'b1; end
        4'd3:    begin op_a = $signed(ValW'(wa)); op_b = n0.y; op_first = 1'b1;
                       op_comp = 2'd1; end
        4'd4:    begin op_a = $signed(ValW'(wb)); op_b = n1.y; op_comp = 2'd1; end
        4'd5:    begin op_a = $signed(ValW'(wc)); op_b = n2.y; op_last = 1'b1;
                       op_comp = 2'd1; end
        4'd6:    begin op_a = $signed(ValW'(wa)); op_b = n0.z; op_first = 1'b1;
                       op_comp = 2'd2; end
        4'd7:    begin op_a = $signed(ValW'(wb)); op_b = n1.z; op_comp = 2'd2; end
        default: begin op_a = $signed(ValW'(wc)); op_b = n2.z; op_last = 1'b1;
                       op_comp = 2'd2; end
      endcase
    end else begin
      nsteps = 4'd6;
      case (st)
        4'd0:    begin op_a = e1y[ValW-1:0]; op_b = e2z[ValW-1:0]; op_first = 1'b1; end
        4'd1:    begin op_a = e1z[ValW-1:0]; op_b = e2y[ValW-1:0]; op_sub = 1'b1;
                       op_last = 1'b1; end
        4'd2:    begin op_a = e1z[ValW-1:0]; op_b = e2x[ValW-1:0]; op_first = 1'b1;
                       op_comp = 2'd1; end
        4'd3:    begin op_a = e1x[ValW-1:0]; op_b = e2z[ValW-1:0]; op_sub = 1'b1;
                       op_last = 1'b1; op_comp = 2'd1; end
        4'd4:    begin op_a = e1x[ValW-1:0]; op_b = e2y[ValW-1:0]; op_first = 1'b1;
                       op_comp = 2'd2; end
        default: begin op_a = e1y[ValW-1:0]; op_b = e2x[ValW-1:0]; op_sub = 1'b1;
                       op_last = 1'b1; op_comp = 2'd2; end
      endcase
    end
  end

  assign issue    = ((state == S_MUL) || (state == S_SQR)) && (st < nsteps);
  assign acc_base = p_first ? AccW'(0) : acc;
  assign acc_next = p_sub ? acc_base - AccW'(prod) : acc_base + AccW'(prod);
  assign mul_done = p_valid && p_last && (st == nsteps);

  // square root step and divide step
  assign sq_trial  = sq_res + sq_bit;
  assign len       = sq_res[ValW-1:0];
  assign div_shift = {div_rem, div_lo[QuoW-1]};
  assign div_ge    = div_shift >= {1'b0, len};
  assign quo_fin   = {quo[QuoW-2:0], div_ge};
  assign quo_cap   = (quo_fin > QuoW'(NrmOne)) ? QuoW'(NrmOne) : quo_fin;

  always_comb begin
    case (dc)
      2'd0:    begin m_cur = m0; v_neg = v0[ProdW-1]; end
      2'd1:    begin m_cur = m1; v_neg = v1[ProdW-1]; end
      default: begin m_cur = m2; v_neg = v2[ProdW-1]; end
    endcase
  end
  assign num      = {m_cur[ValW-1:0], 16'h0000} + NumW'(len[ValW-1:1]);
  assign q_signed = v_neg ? -$signed(quo_cap[NrmW-1:0]) : $signed(quo_cap[NrmW-1:0]);

  assign out_free = !rsp_valid || rsp_ready;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_cnt == ClrLast) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_acc) state_next = (action == ACT_QUERY) ? S_LOAD : S_FIN;
      end
      S_LOAD: begin
        if (ld == 2'd3) state_next = S_FIT;
      end
      S_FIT: begin
        if (any_nrm || !(e1_big || e2_big)) state_next = S_MUL;
      end
      S_MUL: begin
        if (mul_done) state_next = S_CHK;
      end
      S_CHK: begin
        state_next = ((v0 | v1 | v2) == '0) ? S_FIN : S_SCALE;
      end
      S_SCALE: begin
        if (mx < (ProdW'(1) << 31) && mx >= (ProdW'(1) << 29)) state_next = S_SQR;
      end
      S_SQR: begin
        if (mul_done) state_next = S_SQRT;
      end
      S_SQRT: begin
        if (it == 5'd31) state_next = S_DIVINIT;
      end
      S_DIVINIT: begin
        state_next = S_DIV;
      end
      S_DIV: begin
        if (it == 5'(QuoW - 1)) state_next = (dc == 2'd2) ? S_FIN : S_DIVINIT;
      end
      S_FIN: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control counters and pipe valid
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      ld        <= '0;
      st        <= '0;
      it        <= '0;
      dc        <= '0;
      p_valid   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      p_valid <= issue;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + AW'(1);
      if (state == S_LOAD) begin
        ld <= ld + 2'd1;
      end else begin
        ld <= '0;
      end
      if (issue) begin
        st <= st + 4'd1;
      end else if (state != S_MUL && state != S_SQR) begin
        st <= '0;
      end else if (mul_done) begin
        st <= '0;
      end
      case (state)
        S_SQRT:    it <= (it == 5'd31) ? '0 : it + 5'd1;
        S_DIV:     it <= (it == 5'(QuoW - 1)) ? '0 : it + 5'd1;
        default:   it <= '0;
      endcase
      if (state == S_DIV && it == 5'(QuoW - 1)) begin
        dc <= dc + 2'd1;
      end else if (state == S_IDLE) begin
        dc <= '0;
      end
      if (state == S_FIN && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod    <= op_a * op_b;
    p_sub   <= op_sub;
    p_first <= op_first;
    p_last  <= op_last;
    p_comp  <= op_comp;
    if (p_valid) acc <= acc_next;

    case (state)
      S_IDLE: begin
        if (req_acc) begin
          ia <= index_a;
          ib <= index_b;
          ic <= index_c;
          wa <= weight_a;
          wb <= weight_b;
          wc <= weight_c;
          nx <= '0;
          ny <= '0;
          nz <= '0;
          smooth_r <= 1'b0;
          degen_r  <= 1'b0;
        end
      end
      S_LOAD: begin
        case (ld)
          2'd1: begin
            p0 <= vd;
            n0 <= nd;
          end
          2'd2: begin
            e1x <= EdgeW'(vd.x) - EdgeW'(p0.x);
            e1y <= EdgeW'(vd.y) - EdgeW'(p0.y);
            e1z <= EdgeW'(vd.z) - EdgeW'(p0.z);
            n1  <= nd;
          end
          2'd3: begin
            e2x <= EdgeW'(vd.x) - EdgeW'(p0.x);
            e2y <= EdgeW'(vd.y) - EdgeW'(p0.y);
            e2z <= EdgeW'(vd.z) - EdgeW'(p0.z);
            n2  <= nd;
          end
          default: ;
        endcase
      end
      S_FIT: begin
        // halve an edge, rounding down, until it fits the multiplier
        smooth_r <= any_nrm;
        if (e1_big) begin
          e1x <= e1x >>> 1;
          e1y <= e1y >>> 1;
          e1z <= e1z >>> 1;
        end
        if (e2_big) begin
          e2x <= e2x >>> 1;
          e2y <= e2y >>> 1;
          e2z <= e2z >>> 1;
        end
      end
      S_MUL: begin
        if (p_valid && p_last) begin
          case (p_comp)
            2'd0:    v0 <= acc_next[ProdW-1:0];
            2'd1:    v1 <= acc_next[ProdW-1:0];
            default: v2 <= acc_next[ProdW-1:0];
          endcase
        end
      end
      S_CHK: begin
        m0 <= mag64(v0);
        m1 <= mag64(v1);
        m2 <= mag64(v2);
        degen_r <= ((v0 | v1 | v2) == '0);
      end
      S_SCALE: begin
        // bring the largest magnitude into [2^29, 2^31)
        if (mx >= (ProdW'(1) << 39)) begin
          m0 <= m0 >> 8;
          m1 <= m1 >> 8;
          m2 <= m2 >> 8;
        end else if (mx >= (ProdW'(1) << 31)) begin
          m0 <= m0 >> 1;
          m1 <= m1 >> 1;
          m2 <= m2 >> 1;
        end else if (mx < (ProdW'(1) << 21)) begin
          m0 <= m0 << 8;
          m1 <= m1 << 8;
          m2 <= m2 << 8;
        end else if (mx < (ProdW'(1) << 29)) begin
          m0 <= m0 << 1;
          m1 <= m1 << 1;
          m2 <= m2 << 1;
        end
      end
      S_SQR: begin
        if (mul_done) begin
          sq_rem <= acc_next[ProdW-1:0];
          sq_res <= '0;
          sq_bit <= ProdW'(1) << 62;
        end
      end
      S_SQRT: begin
        if (sq_rem >= sq_trial) begin
          sq_rem <= sq_rem - sq_trial;
          sq_res <= (sq_res >> 1) + sq_bit;
        end else begin
          sq_res <= sq_res >> 1;
        end
        sq_bit <= sq_bit >> 2;
      end
      S_DIVINIT: begin
        div_rem <= ValW'(num[NumW-1:QuoW]);
        div_lo  <= num[QuoW-1:0];
        quo     <= '0;
      end
      S_DIV: begin
        // one quotient bit per cycle, rounded numerator
        div_rem <= div_ge ? ValW'(div_shift - {1'b0, len}) : div_shift[ValW-1:0];
        div_lo  <= div_lo << 1;
        quo     <= quo_fin;
        if (it == 5'(QuoW - 1)) begin
          case (dc)
            2'd0:    nx <= q_signed;
            2'd1:    ny <= q_signed;
            default: nz <= q_signed;
          endcase
        end
      end
      S_FIN: begin
        if (out_free) begin
          normal_x    <= nx;
          normal_y    <= ny;
          normal_z    <= nz;
          smooth_used <= smooth_r;
          degenerate  <= degen_r;
        end
      end
      default: ;
    endcase
  end

  // response checks
  assign nrm_in_range = normal_x <= NrmOne && normal_x >= -NrmOne &&
                        normal_y <= NrmOne && normal_y >= -NrmOne &&
                        normal_z <= NrmOne && normal_z >= -NrmOne;
  assign nrm_is_zero  = normal_x == '0 && normal_y == '0 && normal_z == '0;

  `CHK_ALL(a_clear_after_reset, rst |=> !req_ready, "request taken during table clear")
  `CHK_RUN(a_len_scaled, (state == S_DIV) |-> (len >= (ValW'(1) << 29)), "length not scaled")
  `CHK_RUN(a_unit_range, rsp_valid |-> nrm_in_range, "normal out of range")
  `CHK_RUN(a_degen_zero, (rsp_valid && degenerate) |-> nrm_is_zero, "degenerate with nonzero normal")

endmodule

`default_nettype wire
